[rtl/pdps_pkg.sv]
// ----------------------------------------------------------------------------
// pdps_pkg
// Shared types and constants for the paste danger pattern scanner: pattern
// texts, their lengths and places in the list, verdict and reason codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pdps_pkg;

  localparam int WIN_DEPTH = 14;
  localparam int NUM_PATS  = 15;
  localparam int BUF_BYTES = WIN_DEPTH + 1;

  // right-aligned: last character of a pattern sits in bits [7:0]
  typedef logic [8*BUF_BYTES-1:0] pat_text_t;

  localparam pat_text_t PAT_TEXT [NUM_PATS] = '{
    pat_text_t'("base64 -d"),
    pat_text_t'("| bash"),
    pat_text_t'("rm -rf /"),
    pat_text_t'("mkfs."),
    pat_text_t'("dd if=/dev/zero"),
    pat_text_t'("> /dev/sd"),
    pat_text_t'("chmod -R 777 /"),
    pat_text_t'(":(){ :|:& };:"),
    pat_text_t'("shutdown"),
    pat_text_t'("reboot"),
    pat_text_t'("wipefs"),
    pat_text_t'("format c:"),
    pat_text_t'("curl"),
    pat_text_t'("wget"),
    pat_text_t'("sudo ")
  };

  localparam logic [3:0] PAT_LEN [NUM_PATS] = '{
    4'd9, 4'd6, 4'd8, 4'd5, 4'd15, 4'd9, 4'd14, 4'd13,
    4'd8, 4'd6, 4'd6, 4'd9, 4'd4, 4'd4, 4'd5
  };

  localparam int P_B64     = 0;
  localparam int P_PIPE    = 1;
  localparam int P_DANGER0 = 2;
  localparam int P_NDANGER = 10;
  localparam int P_CURL    = 12;
  localparam int P_WGET    = 13;
  localparam int P_SUDO    = 14;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic [7:0] CFG_ENABLE_CHECK  = 8'd0;
  localparam logic [7:0] CFG_WARN_DOWNLOAD = 8'd1;
  localparam logic [7:0] CFG_SUDO_CHECK    = 8'd2;
  localparam logic [7:0] CFG_WARN_MULTI    = 8'd3;

  typedef enum logic [1:0] {
    VERDICT_SAFE   = 2'd0,
    VERDICT_DANGER = 2'd1,
    VERDICT_SUDO   = 2'd2,
    VERDICT_MULTI  = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_ENC_PIPE = 3'd1,
    REASON_PATTERN  = 3'd2,
    REASON_DL_PIPE  = 3'd3,
    REASON_SUDO     = 3'd4,
    REASON_MULTI    = 3'd5
  } reason_e;

  // per-beat control handed to every cell and to the matcher
  typedef struct packed {
    logic shift;   // a byte was accepted
    logic clear;   // end of paste accepted
  } cell_ctrl_t;

  typedef struct packed {
    verdict_e    verdict;
    reason_e     reason;
    logic [3:0]  pattern_index;
    logic [15:0] line_count;
  } result_t;

endpackage

`default_nettype wire

[rtl/pdps_win_cell.sv]
// ----------------------------------------------------------------------------
// pdps_win_cell
// One byte of the history window: holds a byte and a filled flag and takes
// its neighbour's contents on every accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pdps_win_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pdps_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              filled_i,
  output logic      [7:0]        byte_o,
  output logic                   filled_o
);

  logic [7:0] byte_q;
  logic       filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      filled_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      filled_q <= filled_i;
    end
  end

  // payload only matters while filled
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o   = byte_q;
  assign filled_o = filled_q;

endmodule

`default_nettype wire

[rtl/pdps_match.sv]
// ----------------------------------------------------------------------------
// pdps_match
// Compares the window plus the incoming byte against every pattern at once,
// keeps the sticky found flags and the saturating newline count.
// ----------------------------------------------------------------------------
`default_nettype none

module pdps_match #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pdps_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [pdps_pkg::WIN_DEPTH-1:0][7:0] win_byte_i,
  input  wire logic [pdps_pkg::WIN_DEPTH-1:0]      win_filled_i,
  input  wire logic [7:0]                  cur_byte_i,
  output logic      [pdps_pkg::NUM_PATS-1:0]       found_o,
  output logic      [COUNT_WIDTH-1:0]      newlines_o
);

  logic [pdps_pkg::BUF_BYTES-1:0][7:0] buf_byte;
  logic [pdps_pkg::BUF_BYTES-1:0]      buf_filled;
  logic [pdps_pkg::NUM_PATS-1:0]       hit;
  logic [pdps_pkg::NUM_PATS-1:0]       found_q, found_d;
  logic [COUNT_WIDTH-1:0]              count_q, count_d;

  always_comb begin
    buf_byte   = {cur_byte_i, win_byte_i};
    buf_filled = {1'b1, win_filled_i};
  end

  // position j of the buffer lines up with byte (14 - j) of a pattern text
  always_comb begin
    for (int i = 0; i < pdps_pkg::NUM_PATS; i++) begin
      hit[i] = 1'b1;
      for (int j = 0; j < pdps_pkg::BUF_BYTES; j++) begin
        if ((pdps_pkg::BUF_BYTES - 1 - j) < int'(pdps_pkg::PAT_LEN[i])) begin
          if (!buf_filled[j] ||
              buf_byte[j] != pdps_pkg::PAT_TEXT[i][8*(pdps_pkg::BUF_BYTES-1-j) +: 8]) begin
            hit[i] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    found_d = found_q;
    count_d = count_q;
    if (ctrl_i.shift) begin
      found_d = found_q | hit;
      if (cur_byte_i == pdps_pkg::NEWLINE && count_q != {COUNT_WIDTH{1'b1}}) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      found_q <= '0;
      count_q <= '0;
    end else begin
      found_q <= found_d;
      count_q <= count_d;
    end
  end

  // state including the current byte, for the verdict on the closing beat
  assign found_o    = found_d;
  assign newlines_o = count_d;

endmodule

`default_nettype wire

[rtl/paste_danger_pattern_scan_core.sv]
// ----------------------------------------------------------------------------
// paste_danger_pattern_scan_core
// Scans a pasted text byte by byte for dangerous substrings and gives one
// verdict per paste.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   has_byte, data_byte, last_of_paste
//  out      output     out_valid_o / out_stall_i verdict, reason, pattern_index, line_count
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one beat a cycle while in_stall_o is low; a byte is matched in the cycle it arrives;
// the verdict is registered at the closing beat, into the skid entry if output is held.
// a two-entry output (register plus skid) lets input continue while a verdict
// waits; input stalls only once the skid entry holds a second verdict.
// reset empties the window and all flags and sets every config bit to one.
// ----------------------------------------------------------------------------
`default_nettype none

module paste_danger_pattern_scan_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        has_byte_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_of_paste_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  verdict_o,
  output logic      [2:0]  reason_o,
  output logic      [3:0]  pattern_index_o,
  output logic      [15:0] line_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic        cfg_data_i
);

  localparam int WD = pdps_pkg::WIN_DEPTH;

  logic                 in_acc;
  pdps_pkg::cell_ctrl_t ctrl;

  logic [WD-1:0][7:0]   win_byte;
  logic [WD-1:0]        win_filled;
  logic [WD:0][7:0]     chain_byte;
  logic [WD:0]          chain_filled;

  logic [pdps_pkg::NUM_PATS-1:0] found;
  logic [COUNT_WIDTH-1:0]        newlines;

  logic enable_q, warn_dl_q, sudo_chk_q, warn_multi_q;

  pdps_pkg::result_t res;
  pdps_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              push, out_take;

  logic [COUNT_WIDTH:0] lines_ext;
  logic [32:0]          lines_wide;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      warn_dl_q    <= 1'b1;
      sudo_chk_q   <= 1'b1;
      warn_multi_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pdps_pkg::CFG_ENABLE_CHECK:  enable_q     <= cfg_data_i;
        pdps_pkg::CFG_WARN_DOWNLOAD: warn_dl_q    <= cfg_data_i;
        pdps_pkg::CFG_SUDO_CHECK:    sudo_chk_q   <= cfg_data_i;
        pdps_pkg::CFG_WARN_MULTI:    warn_multi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign ctrl.shift = in_acc && has_byte_i;
  assign ctrl.clear = in_acc && last_of_paste_i;

  // window chain: newest byte enters at the top cell
  assign chain_byte[WD]   = data_byte_i;
  assign chain_filled[WD] = 1'b1;

  for (genvar k = 0; k < WD; k++) begin : g_cell
    pdps_win_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .byte_i   (chain_byte[k+1]),
      .filled_i (chain_filled[k+1]),
      .byte_o   (chain_byte[k]),
      .filled_o (chain_filled[k])
    );
    assign win_byte[k]   = chain_byte[k];
    assign win_filled[k] = chain_filled[k];
  end

  pdps_match #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .win_byte_i   (win_byte),
    .win_filled_i (win_filled),
    .cur_byte_i   (data_byte_i),
    .found_o      (found),
    .newlines_o   (newlines)
  );

  // newline count plus one, saturating at the counter and at 16 bits
  always_comb begin
    lines_ext = {1'b0, newlines};
    if (newlines != {COUNT_WIDTH{1'b1}}) begin
      lines_ext = lines_ext + 1'b1;
    end
    lines_wide = 33'(lines_ext);
  end

  always_comb begin
    res.verdict       = pdps_pkg::VERDICT_SAFE;
    res.reason        = pdps_pkg::REASON_NONE;
    res.pattern_index = '0;
    res.line_count    = '0;
    if (found[pdps_pkg::P_B64] && found[pdps_pkg::P_PIPE]) begin
      res.verdict = pdps_pkg::VERDICT_DANGER;
      res.reason  = pdps_pkg::REASON_ENC_PIPE;
    end else if (enable_q) begin
      if (|found[pdps_pkg::P_DANGER0 +: pdps_pkg::P_NDANGER]) begin
        res.verdict = pdps_pkg::VERDICT_DANGER;
        res.reason  = pdps_pkg::REASON_PATTERN;
        // lowest listed pattern wins
        for (int i = pdps_pkg::P_NDANGER - 1; i >= 0; i--) begin
          if (found[pdps_pkg::P_DANGER0 + i]) begin
            res.pattern_index = 4'(i);
          end
        end
      end else if (warn_dl_q && found[pdps_pkg::P_PIPE] &&
                   (found[pdps_pkg::P_CURL] || found[pdps_pkg::P_WGET])) begin
        res.verdict = pdps_pkg::VERDICT_DANGER;
        res.reason  = pdps_pkg::REASON_DL_PIPE;
      end else if (sudo_chk_q && found[pdps_pkg::P_SUDO]) begin
        res.verdict = pdps_pkg::VERDICT_SUDO;
        res.reason  = pdps_pkg::REASON_SUDO;
      end else if (warn_multi_q && newlines != '0) begin
        res.verdict    = pdps_pkg::VERDICT_MULTI;
        res.reason     = pdps_pkg::REASON_MULTI;
        res.line_count = (lines_wide > 33'h0FFFF) ? 16'hFFFF : lines_wide[15:0];
      end
    end
  end

  // output register with skid entry
  assign push     = ctrl.clear;
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = out_q.verdict;
  assign reason_o        = out_q.reason;
  assign pattern_index_o = out_q.pattern_index;
  assign line_count_o    = out_q.line_count;

endmodule

`default_nettype wire
